// ===== src/ptt_pkg.sv =====
// shared types and constants of the titre trajectory block
`default_nettype none
package ptt_pkg;

  localparam int MAX_INFECTIONS_DEF = 16;
  localparam int VALUE_WIDTH_DEF    = 32;

  localparam int VAL_W  = 32;                // q16.16 field width
  localparam int RISE_W = 31;
  localparam int FRAC_W = 16;
  localparam int DIV_W  = VAL_W + FRAC_W;    // |boost| << 16
  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_SAMPLE = 2'd2
  } action_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  slope;
    logic signed [VAL_W-1:0]  decay;
    logic        [RISE_W-1:0] rise;
    logic signed [VAL_W-1:0]  boost;
    logic signed [VAL_W-1:0]  itime;
  } ent_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage
`default_nettype wire

// ===== src/piecewise_titre_trajectory_top.sv =====
// top level of the piecewise titre trajectory block
//
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+----------------------------------------
// in       | in  | in_tvalid/tready   | tdata fields, tuser action, tlast last
// out      | out | out_tvalid/tready  | tdata titre, tlast final flag
// cfg      | in  | cfg_wr_en          | cfg_wr_data lower titre bound
//
// a start word sets the base titre and empties the table; a load word into a
// table that is not full holds the input while the bit-serial slope divider
// (48 quotient bits) runs; a sample word with no infections goes straight to
// the result state, otherwise it steps through table read, operand select,
// multiply and sum per infection it advances over, then once for the sample
// synchronous active-low reset clears counters, base titre and bound; the
// table memory holds no reset and its entries are used only below the fill count
// a finished titre waits in the output register; the next word is taken
// meanwhile and only a sample that completes stalls until the slot is free
`default_nettype none
module piecewise_titre_trajectory_top #(
  parameter int MAX_INFECTIONS = ptt_pkg::MAX_INFECTIONS_DEF,
  parameter int VALUE_WIDTH    = ptt_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // start_titre, infection_time, boost, rise_time, decay_rate, sample_time, pad
  input  wire logic [ptt_pkg::IN_DATA_W-1:0] in_tdata,
  // action
  input  wire logic [1:0]   in_tuser,
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // titre
  output logic [ptt_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic              out_tlast,
  input  wire logic         cfg_wr_en,
  input  wire logic [31:0]  cfg_wr_data
);

  localparam int IW = (MAX_INFECTIONS > 1) ? $clog2(MAX_INFECTIONS) : 1;
  localparam int CW = $clog2(MAX_INFECTIONS + 1);
  localparam int BW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;   // base width
  localparam int QW = 50;                                      // product >> 16
  localparam int SW = ((BW > QW) ? BW : QW) + 2;               // sum width
  localparam int PW = 66;                                      // 32 x 34 product
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-VALUE_WIDTH+1){1'b0}},
                                             {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_RD, S_EVAL, S_MUL, S_SUM, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    M_BASE, M_RISE, M_DECAY
  } mode_t;

  state_t state_r;
  mode_t  mode_r;

  // input field slices
  logic signed [31:0] f_start, f_itime, f_boost, f_decay, f_sample;
  logic        [30:0] f_rise;
  assign f_start  = in_tdata[31:0];
  assign f_itime  = in_tdata[63:32];
  assign f_boost  = in_tdata[95:64];
  assign f_rise   = in_tdata[126:96];
  assign f_decay  = in_tdata[158:127];
  assign f_sample = in_tdata[190:159];

  logic                 accept;
  logic signed [31:0]   lower_r;
  logic [CW-1:0]        cnt_r;
  logic [IW-1:0]        cur_r;
  logic signed [BW-1:0] base_r;
  logic signed [31:0]   t_r;
  logic                 last_r;
  ptt_pkg::ent_t        load_r;
  logic                 adv_r;
  logic signed [31:0]   opa_r;
  logic signed [33:0]   opb_r;
  logic signed [31:0]   boost_r;
  logic signed [PW-1:0] prod_r;
  logic [31:0]          res_r;
  logic                 out_valid_r;
  logic [31:0]          out_data_r;
  logic                 out_last_r;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // slope divider
  ptt_pkg::div_ctl_t            div_ctl;
  logic [ptt_pkg::DIV_W-1:0]    div_q;
  logic [31:0]                  abs_boost;
  logic                         div_start;
  logic signed [31:0]           slope;

  assign abs_boost = f_boost[31] ? (32'd0 - f_boost) : f_boost;
  assign div_start = accept && (ptt_pkg::action_t'(in_tuser) == ptt_pkg::ACT_LOAD)
                     && (cnt_r < CW'(MAX_INFECTIONS));

  ptt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({abs_boost, 16'd0}),
    .divisor  (f_rise),
    .ctl      (div_ctl),
    .quotient (div_q)
  );

  // truncate toward zero then saturate to 32 bit signed
  always_comb begin
    if (load_r.rise == '0) begin
      slope = '0;
    end else if (!load_r.boost[31]) begin
      slope = (div_q > ptt_pkg::DIV_W'(32'h7fff_ffff)) ? 32'sh7fff_ffff : div_q[31:0];
    end else begin
      slope = (div_q > ptt_pkg::DIV_W'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                        : (32'd0 - div_q[31:0]);
    end
  end

  // table memory: current and next infection read each cycle
  ptt_pkg::ent_t ent_c, ent_n, wr_ent;
  logic          mem_we;
  logic [CW-1:0] cur_inc;

  assign cur_inc = CW'(cur_r) + 1'b1;
  assign mem_we  = (state_r == S_DIV) && div_ctl.done;
  always_comb begin
    wr_ent       = load_r;
    wr_ent.slope = slope;
  end

  // loads write only at the fill count and samples use entries only below it, so
  // a sample never uses an entry that a load is writing
  ptt_mem #(.DEPTH(MAX_INFECTIONS), .AW(IW)) u_mem (
    .clk       (clk),
    .wr_en     (mem_we),
    .wr_addr   (cnt_r[IW-1:0]),
    .wr_data   (wr_ent),
    .rd_addr_a (cur_r),
    .rd_addr_b (cur_inc[IW-1:0]),
    .rd_data_a (ent_c),
    .rd_data_b (ent_n)
  );

  // segment select: advance to next infection time or evaluate at sample
  logic               adv;
  logic signed [31:0] tt;
  logic signed [32:0] dt;
  logic signed [33:0] dd;

  assign adv = (cur_inc < cnt_r) && (t_r > ent_n.itime);
  assign tt  = adv ? ent_n.itime : t_r;
  assign dt  = {tt[31], tt} - {ent_c.itime[31], ent_c.itime};
  assign dd  = {dt[32], dt} - {3'b000, ent_c.rise};

  // sum, saturate, clamp
  logic signed [QW-1:0] q;
  logic signed [SW-1:0] base_x, boost_x, q_x, sum, sat, lower_x, clamped;
  logic signed [BW-1:0] res;

  assign q       = prod_r[PW-1:ptt_pkg::FRAC_W];   // floor by arithmetic shift
  assign base_x  = {{(SW-BW){base_r[BW-1]}}, base_r};
  assign boost_x = {{(SW-32){boost_r[31]}}, boost_r};
  assign q_x     = {{(SW-QW){q[QW-1]}}, q};
  assign lower_x = {{(SW-32){lower_r[31]}}, lower_r};

  always_comb begin
    case (mode_r)
      M_RISE:  sum = base_x + q_x;
      M_DECAY: sum = base_x + boost_x - q_x;
      default: sum = base_x;
    endcase
    if (mode_r == M_BASE) begin
      sat = sum;
    end else if (sum > SAT_HI) begin
      sat = SAT_HI;
    end else if (sum < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = sum;
    end
    clamped = (sat < lower_x) ? lower_x : sat;
    res     = clamped[BW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lower_r     <= '0;
      cnt_r       <= '0;
      cur_r       <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        lower_r <= cfg_wr_data;
      end
      // the result state refills the slot itself
      if (out_valid_r && out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            t_r    <= f_sample;
            last_r <= in_tlast;
            case (ptt_pkg::action_t'(in_tuser))
              ptt_pkg::ACT_START: begin
                base_r <= BW'(f_start);
                cnt_r  <= '0;
                cur_r  <= '0;
              end
              ptt_pkg::ACT_LOAD: begin
                load_r.itime <= f_itime;
                load_r.boost <= f_boost;
                load_r.rise  <= f_rise;
                load_r.decay <= f_decay;
                load_r.slope <= '0;
                if (div_start) begin
                  state_r <= S_DIV;
                end
              end
              ptt_pkg::ACT_SAMPLE: begin
                if (cnt_r == '0) begin
                  res_r   <= base_r[31:0];   // no infections: base unclamped
                  state_r <= S_OUT;
                end else begin
                  state_r <= S_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (div_ctl.done) begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_RD: begin
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          adv_r   <= adv;
          boost_r <= ent_c.boost;
          if (dt <= 0) begin
            mode_r <= M_BASE;
            opa_r  <= '0;
            opb_r  <= '0;
          end else if (dd <= 0) begin
            mode_r <= M_RISE;
            opa_r  <= ent_c.slope;
            opb_r  <= {dt[32], dt};
          end else begin
            mode_r <= M_DECAY;
            opa_r  <= ent_c.decay;
            opb_r  <= dd;
          end
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= PW'(opa_r * opb_r);
          state_r <= S_SUM;
        end
        S_SUM: begin
          if (adv_r) begin
            base_r  <= res;
            cur_r   <= cur_r + 1'b1;
            state_r <= S_RD;
          end else begin
            res_r   <= res[31:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            out_last_r  <= last_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // fill count never passes the table depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_INFECTIONS))
    else $error("infection count beyond table depth");

  // current infection stays inside the filled part of the table
  a_cur_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (CW'(cur_r) < cnt_r))
    else $error("current infection beyond fill count");

  // a table write only ends a running slope division
  a_wr_div: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> $past(div_ctl.busy))
    else $error("table write without a slope division");

  // a new result only comes out of the result state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == S_OUT)
    else $error("result shown outside the result state");

endmodule
`default_nettype wire

// ===== src/ptt_mem.sv =====
// infection table: one write port, two registered read ports
`default_nettype none
module ptt_mem #(
  parameter int DEPTH = ptt_pkg::MAX_INFECTIONS_DEF,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire ptt_pkg::ent_t wr_data,
  input  wire logic [AW-1:0] rd_addr_a,
  input  wire logic [AW-1:0] rd_addr_b,
  output ptt_pkg::ent_t      rd_data_a,
  output ptt_pkg::ent_t      rd_data_b
);

  ptt_pkg::ent_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule
`default_nettype wire

// ===== src/ptt_div.sv =====
// restoring divider, one quotient bit per cycle, for the rise slope
`default_nettype none
module ptt_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [ptt_pkg::DIV_W-1:0]  dividend,
  input  wire logic [ptt_pkg::RISE_W-1:0] divisor,
  output ptt_pkg::div_ctl_t               ctl,
  output logic      [ptt_pkg::DIV_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(ptt_pkg::DIV_W + 1);

  logic [CNT_W-1:0]          cnt_r;
  logic [ptt_pkg::RISE_W:0]  rem_r;
  logic [ptt_pkg::RISE_W-1:0] dsr_r;
  logic                      busy_r;
  logic                      done_r;
  logic [ptt_pkg::RISE_W+1:0] trial;
  logic [ptt_pkg::RISE_W+1:0] shifted;

  assign shifted = {rem_r, quotient[ptt_pkg::DIV_W-1]};
  assign trial   = shifted - {2'b00, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r   <= 1'b1;
        cnt_r    <= CNT_W'(ptt_pkg::DIV_W);
        rem_r    <= '0;
        dsr_r    <= divisor;
        quotient <= dividend;
      end else if (busy_r) begin
        if (!trial[ptt_pkg::RISE_W+1]) begin
          rem_r    <= trial[ptt_pkg::RISE_W:0];
          quotient <= {quotient[ptt_pkg::DIV_W-2:0], 1'b1};
        end else begin
          rem_r    <= shifted[ptt_pkg::RISE_W:0];
          quotient <= {quotient[ptt_pkg::DIV_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign ctl = '{start: start, busy: busy_r, done: done_r};

endmodule
`default_nettype wire

// ===== sim/piecewise_titre_trajectory_top_test.sv =====
// self-checking testbench for the piecewise titre trajectory block
`timescale 1ns / 1ps
`default_nettype none
module piecewise_titre_trajectory_top_test;

  localparam int TABLE_DEPTH = 16;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam longint CYCLE_LIMIT = 2_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [191:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic out_tlast;
  logic cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  piecewise_titre_trajectory_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    // start_titre, infection_time, boost, rise_time, decay_rate, sample_time, pad
    .in_tdata(in_tdata),
    // action
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    // titre
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // expected titre words, oldest first
  typedef struct {
    logic [31:0] titre;
    logic        final_flag;
  } titre_word_t;
  titre_word_t titre_expect_q[$];

  // shadow copy of the infection table and trajectory state
  longint inf_time[TABLE_DEPTH], inf_boost[TABLE_DEPTH], inf_rise[TABLE_DEPTH];
  longint inf_decay[TABLE_DEPTH], inf_slope[TABLE_DEPTH];
  int unsigned inf_count, inf_cur;
  longint base_lvl, floor_lvl;

  int mismatch_count = 0;
  int titre_seen = 0;
  int sent_count = 0;
  longint cycle_count = 0;
  bit idle_on = 1'b1;      // random gaps and stalls enabled
  bit hold_off = 1'b0;     // long receiver hold-off requested

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor toward minus infinity of v / 2^16
  function automatic longint q16_floor(longint v);
    return v >>> 16;
  endfunction

  function automatic longint titre_at(int unsigned k, longint t, longint base);
    longint ti, tp;
    ti = inf_time[k];
    tp = inf_rise[k];
    if (t <= ti) return base;
    if (t <= ti + tp) return clip32(base + q16_floor(inf_slope[k] * (t - ti)));
    return clip32(base + inf_boost[k] - q16_floor(inf_decay[k] * (t - ti - tp)));
  endfunction

  // update the shadow state for one word; returns 1 if a titre follows
  function automatic bit predict_titre(logic [1:0] act, logic [191:0] d, logic lst,
                                       output titre_word_t w);
    longint t, y, nb, b, r;
    w.titre = '0;
    w.final_flag = lst;
    case (act)
      ptt_pkg::ACT_START: begin
        base_lvl = longint'($signed(d[31:0]));
        inf_count = 0;
        inf_cur = 0;
        return 1'b0;
      end
      ptt_pkg::ACT_LOAD: begin
        if (inf_count >= TABLE_DEPTH) return 1'b0;
        b = longint'($signed(d[95:64]));
        r = longint'(d[126:96]);
        inf_time[inf_count] = longint'($signed(d[63:32]));
        inf_boost[inf_count] = b;
        inf_rise[inf_count] = r;
        inf_decay[inf_count] = longint'($signed(d[158:127]));
        inf_slope[inf_count] = (r != 0) ? clip32((b * 65536) / r) : 0;
        inf_count++;
        return 1'b0;
      end
      ptt_pkg::ACT_SAMPLE: begin
        t = longint'($signed(d[190:159]));
        if (inf_count == 0) begin
          y = base_lvl;   // no infections: base goes out unclamped
        end else begin
          while (inf_cur + 1 < inf_count && t > inf_time[inf_cur + 1]) begin
            nb = titre_at(inf_cur, inf_time[inf_cur + 1], base_lvl);
            if (nb < floor_lvl) nb = floor_lvl;
            base_lvl = nb;
            inf_cur++;
          end
          y = titre_at(inf_cur, t, base_lvl);
          if (y < floor_lvl) y = floor_lvl;
        end
        w.titre = y[31:0];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h (word %0d)", what, got, want, titre_seen);
    mismatch_count++;
  endtask

  // one word to the block; prediction is made on acceptance
  task automatic send_word(logic [1:0] act, logic [191:0] d, logic lst);
    titre_word_t w;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= d;
    in_tlast <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (predict_titre(act, d, lst, w)) titre_expect_q.push_back(w);
    sent_count++;
    // valid stays up until the next word or a drain replaces it
  endtask

  function automatic logic [191:0] pack_word(logic [31:0] st, logic [31:0] it,
    logic [31:0] bo, logic [30:0] ri, logic [31:0] de, logic [31:0] sa);
    return {1'b0, sa, de, ri, bo, it, st};
  endfunction

  task automatic send_start(logic [31:0] st);
    send_word(ptt_pkg::ACT_START,
              pack_word(st, $urandom, $urandom, 31'($urandom), $urandom, $urandom),
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_load(logic [31:0] it, logic [31:0] bo, logic [30:0] ri,
                           logic [31:0] de);
    send_word(ptt_pkg::ACT_LOAD, pack_word($urandom, it, bo, ri, de, $urandom),
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_sample(logic [31:0] sa, logic lst);
    send_word(ptt_pkg::ACT_SAMPLE,
              pack_word($urandom, $urandom, $urandom, 31'($urandom), $urandom, sa), lst);
  endtask

  // wait for every titre, then let a trailing load finish before touching config
  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    while (titre_expect_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_floor(logic [31:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    floor_lvl = longint'($signed(v));
  endtask

  // directed: extremes, every action, full table, zero rise, no infections
  task automatic test_directed();
    send_sample(32'h1234_5678, 1'b0);            // no infections at reset base
    send_start(32'h8000_0000);
    send_sample(32'h7fff_ffff, 1'b1);            // unclamped negative base
    send_word(ACT_UNUSED, '1, 1'b1);             // ignored action
    send_start(32'h0001_0000);
    send_load(32'h0000_0000, 32'h7fff_ffff, 31'd0, 32'h8000_0000);  // zero rise
    send_load(32'h0002_0000, 32'h8000_0000, 31'h7fff_ffff, 32'h7fff_ffff);
    send_load(32'h7fff_0000, 32'h0005_0000, 31'd1, 32'hffff_0000);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_8000, 1'b0);
    send_sample(32'h0003_0000, 1'b0);
    send_sample(32'h7fff_ffff, 1'b1);            // skips to last infection
    send_start(32'h7fff_ffff);
    for (int i = 0; i < TABLE_DEPTH + 2; i++)    // two loads past a full table
      send_load(i << 16, $urandom, 31'($urandom_range(0, 4) << 16), $urandom);
    send_sample(32'h7fff_ffff, 1'b1);
    drain_and_settle();
  endtask

  // well-formed individuals with random content, plus some noise
  task automatic test_random(int n_words, logic [31:0] bnd);
    int n_inf, n_smp;
    logic [31:0] t;
    write_floor(bnd);
    while (n_words > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: any action, any bits
        send_word(2'($urandom_range(0, 3)), {$urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom}, 1'($urandom_range(0, 1)));
        n_words--;
        continue;
      end
      send_start($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20) << 16);
      n_inf = $urandom_range(0, 5) == 0 ? $urandom_range(0, 17) : $urandom_range(0, 4);
      t = $urandom_range(0, 4) << 16;
      for (int i = 0; i < n_inf; i++) begin
        t += $urandom_range(0, 10) << 16;
        if ($urandom_range(0, 7) == 0)
          send_load($urandom, $urandom, 31'($urandom), $urandom);
        else send_load(t, $urandom_range(0, 10) == 0 ? $urandom : $urandom_range(0, 16) << 16,
                       31'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6 << 16)),
                       $urandom_range(0, 8) == 0 ? $urandom : $urandom_range(0, 3 << 16));
      end
      n_smp = $urandom_range(1, 8);
      t = $urandom_range(0, 3) << 16;
      for (int i = 0; i < n_smp; i++) begin
        t += $urandom_range(0, 12 << 16);
        send_sample($urandom_range(0, 9) == 0 ? $urandom : t, i == n_smp - 1);
      end
      n_words -= 2 + n_inf + n_smp;
    end
    drain_and_settle();
  endtask

  // receiver stalls long while samples keep coming
  task automatic test_backpressure();
    send_start(32'h0004_0000);
    send_load(32'h0001_0000, 32'h0008_0000, 31'h0002_0000, 32'h0000_8000);
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++) send_sample((i + 1) << 15, i == 19);
    drain_and_settle();
  endtask

  // result checker
  always @(posedge clk) begin
    titre_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      titre_seen++;
      if (titre_expect_q.size() == 0) begin
        report_mismatch("unexpected titre", out_tdata, '0);
      end else begin
        w = titre_expect_q.pop_front();
        if (out_tdata !== w.titre) report_mismatch("titre", out_tdata, w.titre);
        if (out_tlast !== w.final_flag)
          report_mismatch("final flag", {31'd0, out_tlast}, {31'd0, w.final_flag});
      end
    end
  end

  // receiver: random stall bursts, or a long hold-off when asked
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d titres pending", cycle_count,
               titre_expect_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    inf_count = 0;
    inf_cur = 0;
    base_lvl = 0;
    floor_lvl = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(500, 32'h8000_0000);   // lowest bound: never clamps
    test_random(450, 32'h0003_0000);
    test_random(400, 32'h7fff_ffff);   // highest bound: every sample with infections clamps
    test_backpressure();
    idle_on = 1'b0;                    // closing stretch runs at full rate
    test_random(450, 32'h0000_0000);
    $display("covered %0d words and %0d titres over four lower bounds,", sent_count,
             titre_seen);
    $display("including a full table, zero rise times and a long output stall");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== piecewise_titre_trajectory_top.f =====
src/ptt_pkg.sv
src/ptt_mem.sv
src/ptt_div.sv
src/piecewise_titre_trajectory_top.sv
sim/piecewise_titre_trajectory_top_test.sv
